[src/modbus_rtu_master_transaction_defines.svh]
// Assertion macros for the Modbus RTU master transaction engine.
`ifndef MODBUS_RTU_MASTER_TRANSACTION_DEFINES_SVH
`define MODBUS_RTU_MASTER_TRANSACTION_DEFINES_SVH
`ifndef SYNTH
`define MRTU_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("mrtu assertion failed");
`define MRTU_NEVER(lbl, clk, rstn, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
        else $error("mrtu forbidden condition");
`else
`define MRTU_ASSERT(lbl, clk, rstn, prop)
`define MRTU_NEVER(lbl, clk, rstn, expr)
`endif
`endif

[src/mrtu_pkg.sv]
// Shared types, codes and constants of the Modbus RTU master transaction engine.
package mrtu_pkg;
    localparam int MAX_REGS = 16;
    localparam int IDX_W    = $clog2(MAX_REGS);
    localparam int REM_W    = $clog2(MAX_REGS + 1);
    localparam int IN_W     = 88;
    localparam int OUT_W    = 64;

    localparam logic [2:0] ACT_START = 3'd0;
    localparam logic [2:0] ACT_DATA  = 3'd1;
    localparam logic [2:0] ACT_BYTE  = 3'd2;
    localparam logic [2:0] ACT_TICK  = 3'd3;
    localparam logic [2:0] ACT_LINE  = 3'd4;

    localparam logic [1:0] FK_READ    = 2'd0;
    localparam logic [1:0] FK_WSINGLE = 2'd1;
    localparam logic [1:0] FK_WMULTI  = 2'd2;

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_SEND = 2'd1;
    localparam logic [1:0] PH_RECV = 2'd2;

    localparam logic [1:0] KIND_TX     = 2'd0;
    localparam logic [1:0] KIND_WORD   = 2'd1;
    localparam logic [1:0] KIND_STATUS = 2'd2;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_FRAME   = 3'd1;
    localparam logic [2:0] ST_CRC     = 3'd2;
    localparam logic [2:0] ST_TIMEOUT = 3'd3;
    localparam logic [2:0] ST_LINE    = 3'd4;

    localparam logic [3:0] TXS_SLAVE   = 4'd0;
    localparam logic [3:0] TXS_FUNC    = 4'd1;
    localparam logic [3:0] TXS_ADDR_HI = 4'd2;
    localparam logic [3:0] TXS_ADDR_LO = 4'd3;
    localparam logic [3:0] TXS_SEC_HI  = 4'd4;
    localparam logic [3:0] TXS_SEC_LO  = 4'd5;
    localparam logic [3:0] TXS_BCNT    = 4'd6;
    localparam logic [3:0] TXS_WORD_HI = 4'd7;
    localparam logic [3:0] TXS_WORD_LO = 4'd8;
    localparam logic [3:0] TXS_CRC_LO  = 4'd9;
    localparam logic [3:0] TXS_CRC_HI  = 4'd10;

    localparam logic [3:0] OP_NONE   = 4'd0;
    localparam logic [3:0] OP_LATCH  = 4'd1;
    localparam logic [3:0] OP_START  = 4'd2;
    localparam logic [3:0] OP_DATA   = 4'd3;
    localparam logic [3:0] OP_TX     = 4'd4;
    localparam logic [3:0] OP_RX     = 4'd5;
    localparam logic [3:0] OP_WORD   = 4'd6;
    localparam logic [3:0] OP_STATUS = 4'd7;
    localparam logic [3:0] OP_TICK   = 4'd8;

    localparam logic [1:0] RXC_BODY  = 2'd0;
    localparam logic [1:0] RXC_PEND  = 2'd1;
    localparam logic [1:0] RXC_FINAL = 2'd2;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;
    localparam logic [15:0] DEF_TIMEOUT = 16'd1000;

    typedef struct packed {
        logic [3:0]       op;
        logic [3:0]       tx_sel;
        logic             last;
        logic [2:0]       status;
        logic             count_fail;
        logic [IDX_W-1:0] word_idx;
    } t_cmd;

    typedef struct packed {
        logic [2:0]   action;
        logic [1:0]   phase;
        logic [1:0]   kind;
        logic         start_bad;
        logic         out_free;
        logic         crc_busy;
        logic         rem_zero;
        logic [1:0]   rx_case;
        logic         mismatch;
        logic         crc_ok;
        logic [REM_W-1:0] word_cnt;
        logic         wait_le1;
    } t_sts;

    function automatic logic [7:0] func_code(input logic [1:0] k);
        case (k)
            FK_READ:    func_code = 8'h03;
            FK_WSINGLE: func_code = 8'h06;
            FK_WMULTI:  func_code = 8'h10;
            default:    func_code = 8'h00;
        endcase
    endfunction
endpackage

[src/mrtu_dp.sv]
// Datapath: request registers, bitwise CRC unit, read buffer and output register.
`include "modbus_rtu_master_transaction_defines.svh"
module mrtu_dp (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic [mrtu_pkg::IN_W-1:0] i_in_data,
    input  logic [2:0]               i_in_user,
    input  logic                     i_cfg_wr,
    input  logic [15:0]              i_cfg_data,
    input  logic                     i_out_ready,
    input  mrtu_pkg::t_cmd           i_cmd,
    output mrtu_pkg::t_sts           o_sts,
    output logic                     o_out_valid,
    output logic [1:0]               o_out_user,
    output logic [mrtu_pkg::OUT_W-1:0] o_out_data,
    output logic                     o_out_last
);
    import mrtu_pkg::*;

    logic [2:0]  r_in_act;
    logic [1:0]  r_in_fk;
    logic [7:0]  r_in_slave;
    logic [15:0] r_in_sreg, r_in_cnt, r_in_word, r_in_to;
    logic [7:0]  r_in_byte;
    logic [15:0] r_def_to;
    logic [1:0]  r_phase, r_kind;
    logic [7:0]  r_slave;
    logic [15:0] r_addr, r_sec;
    logic [REM_W-1:0] r_rem;
    logic [15:0] r_crc;
    logic [2:0]  r_crc_cnt;
    logic        r_crc_busy;
    logic [7:0]  r_pos, r_pend;
    logic        r_mm;
    logic [15:0] r_wait;
    logic [31:0] r_fail;
    logic [15:0] r_buf [MAX_REGS];
    logic        r_out_valid, r_out_last;
    logic [1:0]  r_out_user;
    logic [OUT_W-1:0] r_out_data;

    logic        out_free;
    logic        emit_op;
    logic [7:0]  tx_b;
    logic [8:0]  rx_len, rx_p2;
    logic [1:0]  rx_case;
    logic [7:0]  psub;
    logic [7:0]  want;
    logic        mm_hit;
    logic [31:0] n_fail;
    logic [15:0] crc_x;

    assign out_free = !r_out_valid || i_out_ready;
    assign emit_op = (i_cmd.op == OP_TX) || (i_cmd.op == OP_WORD) || (i_cmd.op == OP_STATUS);
    assign rx_len = (r_kind == FK_READ) ? (9'd5 + {3'b0, r_sec[4:0], 1'b0}) : 9'd8;
    assign rx_p2  = {1'b0, r_pos} + 9'd2;
    assign rx_case = (rx_p2 < rx_len) ? RXC_BODY : ((rx_p2 == rx_len) ? RXC_PEND : RXC_FINAL);
    assign psub = r_pos - 8'd3;
    assign n_fail = r_fail + {31'b0, i_cmd.count_fail};
    assign crc_x = r_crc ^ {8'b0, tx_b};

    always_comb begin
        case (i_cmd.tx_sel)
            TXS_SLAVE:   tx_b = r_slave;
            TXS_FUNC:    tx_b = func_code(r_kind);
            TXS_ADDR_HI: tx_b = r_addr[15:8];
            TXS_ADDR_LO: tx_b = r_addr[7:0];
            TXS_SEC_HI:  tx_b = r_sec[15:8];
            TXS_SEC_LO:  tx_b = r_sec[7:0];
            TXS_BCNT:    tx_b = {r_sec[6:0], 1'b0};
            TXS_WORD_HI: tx_b = r_in_word[15:8];
            TXS_WORD_LO: tx_b = r_in_word[7:0];
            TXS_CRC_LO:  tx_b = r_crc[7:0];
            TXS_CRC_HI:  tx_b = r_crc[15:8];
            default:     tx_b = 8'h00;
        endcase
    end

    always_comb begin
        case (r_pos)
            8'd2:    want = r_addr[15:8];
            8'd3:    want = r_addr[7:0];
            8'd4:    want = r_sec[15:8];
            default: want = r_sec[7:0];
        endcase
        if (r_pos == 8'd0) begin
            mm_hit = (r_in_byte != r_slave);
        end else if (r_pos == 8'd1) begin
            mm_hit = (r_in_byte != func_code(r_kind));
        end else if (r_kind == FK_READ) begin
            mm_hit = (r_pos == 8'd2) && (r_in_byte != {r_sec[6:0], 1'b0});
        end else begin
            mm_hit = (r_in_byte != want);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_def_to    <= DEF_TIMEOUT;
            r_phase     <= PH_IDLE;
            r_kind      <= FK_READ;
            r_slave     <= 8'd0;
            r_addr      <= 16'd0;
            r_sec       <= 16'd0;
            r_rem       <= '0;
            r_crc       <= CRC_INIT;
            r_crc_cnt   <= 3'd0;
            r_crc_busy  <= 1'b0;
            r_pos       <= 8'd0;
            r_pend      <= 8'd0;
            r_mm        <= 1'b0;
            r_wait      <= 16'd0;
            r_fail      <= 32'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr) begin
                r_def_to <= i_cfg_data;
            end
            if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (r_crc_busy) begin
                r_crc     <= r_crc[0] ? ((r_crc >> 1) ^ CRC_POLY) : (r_crc >> 1);
                r_crc_cnt <= r_crc_cnt + 3'd1;
                if (r_crc_cnt == 3'd7) begin
                    r_crc_busy <= 1'b0;
                end
            end
            case (i_cmd.op)
                OP_START: begin
                    r_kind  <= r_in_fk;
                    r_slave <= r_in_slave;
                    r_addr  <= r_in_sreg;
                    r_sec   <= (r_in_fk == FK_WSINGLE) ? r_in_word : r_in_cnt;
                    r_wait  <= (r_in_to != 16'd0) ? r_in_to : r_def_to;
                    r_crc   <= CRC_INIT;
                    if (r_in_fk == FK_WMULTI) begin
                        r_rem   <= r_in_cnt[REM_W-1:0];
                        r_phase <= PH_SEND;
                    end
                end
                OP_DATA: begin
                    if (r_rem != '0) begin
                        r_rem <= r_rem - REM_W'(1);
                    end
                end
                OP_TX: begin
                    r_out_valid <= 1'b1;
                    if (i_cmd.tx_sel < TXS_CRC_LO) begin
                        r_crc      <= crc_x;
                        r_crc_cnt  <= 3'd0;
                        r_crc_busy <= 1'b1;
                    end else if (i_cmd.tx_sel == TXS_CRC_HI) begin
                        r_phase <= PH_RECV;
                        r_pos   <= 8'd0;
                        r_crc   <= CRC_INIT;
                        r_mm    <= 1'b0;
                        r_pend  <= 8'd0;
                    end
                end
                OP_RX: begin
                    r_pos <= r_pos + 8'd1;
                    if (rx_case == RXC_BODY) begin
                        r_crc      <= r_crc ^ {8'b0, r_in_byte};
                        r_crc_cnt  <= 3'd0;
                        r_crc_busy <= 1'b1;
                        r_mm       <= r_mm | mm_hit;
                        if (r_kind == FK_READ && r_pos > 8'd2 && r_pos[0]) begin
                            r_pend <= r_in_byte;
                        end
                    end else if (rx_case == RXC_PEND) begin
                        r_pend <= r_in_byte;
                    end
                end
                OP_WORD: begin
                    r_out_valid <= 1'b1;
                end
                OP_STATUS: begin
                    r_out_valid <= 1'b1;
                    r_fail      <= n_fail;
                    r_phase     <= PH_IDLE;
                end
                OP_TICK: begin
                    r_wait <= r_wait - 16'd1;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_LATCH) begin
            r_in_act   <= i_in_user;
            r_in_fk    <= i_in_data[1:0];
            r_in_slave <= i_in_data[9:2];
            r_in_sreg  <= i_in_data[25:10];
            r_in_cnt   <= i_in_data[41:26];
            r_in_word  <= i_in_data[57:42];
            r_in_to    <= i_in_data[73:58];
            r_in_byte  <= i_in_data[81:74];
        end
        if (i_cmd.op == OP_RX && rx_case == RXC_BODY && r_kind == FK_READ
                && r_pos > 8'd3 && !r_pos[0] && psub[7:IDX_W+1] == '0) begin
            r_buf[psub[IDX_W:1]] <= {r_pend, r_in_byte};
        end
        case (i_cmd.op)
            OP_TX: begin
                r_out_user <= KIND_TX;
                r_out_data <= {{(OUT_W-8){1'b0}}, tx_b};
                r_out_last <= i_cmd.last;
            end
            OP_WORD: begin
                r_out_user <= KIND_WORD;
                r_out_data <= {{(OUT_W-28){1'b0}}, r_buf[i_cmd.word_idx],
                               4'(i_cmd.word_idx), 8'b0};
                r_out_last <= 1'b0;
            end
            OP_STATUS: begin
                r_out_user <= KIND_STATUS;
                r_out_data <= {1'b0, n_fail, i_cmd.status, 28'b0};
                r_out_last <= 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        o_sts.action    = r_in_act;
        o_sts.phase     = r_phase;
        o_sts.kind      = r_kind;
        o_sts.start_bad = (r_in_fk != FK_READ && r_in_fk != FK_WSINGLE && r_in_fk != FK_WMULTI)
            || (r_in_fk != FK_WSINGLE
                && (r_in_cnt == 16'd0 || r_in_cnt > 16'(MAX_REGS)));
        o_sts.out_free  = out_free;
        o_sts.crc_busy  = r_crc_busy;
        o_sts.rem_zero  = (r_rem == '0);
        o_sts.rx_case   = rx_case;
        o_sts.mismatch  = r_mm;
        o_sts.crc_ok    = ({r_in_byte, r_pend} == r_crc);
        o_sts.word_cnt  = (r_sec > 16'(MAX_REGS)) ? REM_W'(MAX_REGS) : r_sec[REM_W-1:0];
        o_sts.wait_le1  = (r_wait <= 16'd1);
    end

    assign o_out_valid = r_out_valid;
    assign o_out_user  = r_out_user;
    assign o_out_data  = r_out_data;
    assign o_out_last  = r_out_last;

    `MRTU_NEVER(a_tx_crc_idle, i_clk, i_rst_n, i_cmd.op == OP_TX && r_crc_busy)
    `MRTU_NEVER(a_emit_free, i_clk, i_rst_n, emit_op && !out_free)
    `MRTU_ASSERT(a_crc_eight, i_clk, i_rst_n, $rose(r_crc_busy) |-> ##7 r_crc_busy)
endmodule

[src/mrtu_ctrl.sv]
// Controller state machine that sequences the transaction engine.
module mrtu_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  mrtu_pkg::t_sts i_sts,
    output mrtu_pkg::t_cmd o_cmd
);
    import mrtu_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECODE = 3'd1;
    localparam logic [2:0] S_TX     = 3'd2;
    localparam logic [2:0] S_CRC    = 3'd3;
    localparam logic [2:0] S_RX     = 3'd4;
    localparam logic [2:0] S_WORD   = 3'd5;
    localparam logic [2:0] S_STAT   = 3'd6;

    logic [2:0] r_state, n_state;
    logic [3:0] r_sel, n_sel;
    logic       r_end, n_end;
    logic [REM_W-1:0] r_widx, n_widx;
    logic [2:0] r_st, n_st;
    logic       r_cnt, n_cnt;
    logic [3:0] nxt;
    logic       endf;

    always_comb begin
        nxt  = r_sel + 4'd1;
        endf = 1'b0;
        case (r_sel)
            TXS_SEC_LO:  nxt = (i_sts.kind == FK_WMULTI) ? TXS_BCNT : TXS_CRC_LO;
            TXS_BCNT:    endf = 1'b1;
            TXS_WORD_LO: begin
                nxt  = TXS_CRC_LO;
                endf = !i_sts.rem_zero;
            end
            TXS_CRC_HI:  endf = 1'b1;
            default:     nxt = r_sel + 4'd1;
        endcase
    end

    always_comb begin
        n_state = r_state;
        n_sel   = r_sel;
        n_end   = r_end;
        n_widx  = r_widx;
        n_st    = r_st;
        n_cnt   = r_cnt;
        o_in_ready = 1'b0;
        o_cmd   = '0;
        o_cmd.op = OP_NONE;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.op = OP_LATCH;
                    n_state  = S_DECODE;
                end
            end
            S_DECODE: begin
                n_state = S_IDLE;
                case (i_sts.action)
                    ACT_START: begin
                        if (i_sts.phase == PH_IDLE) begin
                            if (i_sts.start_bad) begin
                                n_st    = ST_FRAME;
                                n_cnt   = 1'b0;
                                n_state = S_STAT;
                            end else begin
                                o_cmd.op = OP_START;
                                n_sel    = TXS_SLAVE;
                                n_state  = S_TX;
                            end
                        end
                    end
                    ACT_DATA: begin
                        if (i_sts.phase == PH_SEND) begin
                            o_cmd.op = OP_DATA;
                            n_sel    = TXS_WORD_HI;
                            n_state  = S_TX;
                        end
                    end
                    ACT_BYTE: begin
                        if (i_sts.phase == PH_RECV) begin
                            n_state = S_RX;
                        end
                    end
                    ACT_TICK: begin
                        if (i_sts.phase == PH_RECV) begin
                            if (i_sts.wait_le1) begin
                                n_st    = ST_TIMEOUT;
                                n_cnt   = 1'b1;
                                n_state = S_STAT;
                            end else begin
                                o_cmd.op = OP_TICK;
                            end
                        end
                    end
                    ACT_LINE: begin
                        if (i_sts.phase == PH_RECV) begin
                            n_st    = ST_LINE;
                            n_cnt   = 1'b1;
                            n_state = S_STAT;
                        end
                    end
                    default: n_state = S_IDLE;
                endcase
            end
            S_TX: begin
                if (i_sts.out_free) begin
                    o_cmd.op     = OP_TX;
                    o_cmd.tx_sel = r_sel;
                    o_cmd.last   = endf;
                    n_sel        = nxt;
                    if (r_sel < TXS_CRC_LO) begin
                        n_end   = endf;
                        n_state = S_CRC;
                    end else begin
                        n_state = endf ? S_IDLE : S_TX;
                    end
                end
            end
            S_CRC: begin
                if (!i_sts.crc_busy) begin
                    n_state = r_end ? S_IDLE : S_TX;
                end
            end
            S_RX: begin
                o_cmd.op = OP_RX;
                case (i_sts.rx_case)
                    RXC_BODY: begin
                        n_end   = 1'b1;
                        n_state = S_CRC;
                    end
                    RXC_PEND: n_state = S_IDLE;
                    default: begin
                        if (i_sts.mismatch) begin
                            n_st    = ST_FRAME;
                            n_cnt   = 1'b1;
                            n_state = S_STAT;
                        end else if (!i_sts.crc_ok) begin
                            n_st    = ST_CRC;
                            n_cnt   = 1'b1;
                            n_state = S_STAT;
                        end else begin
                            n_st    = ST_OK;
                            n_cnt   = 1'b0;
                            n_widx  = '0;
                            n_state = (i_sts.kind == FK_READ) ? S_WORD : S_STAT;
                        end
                    end
                endcase
            end
            S_WORD: begin
                if (i_sts.out_free) begin
                    o_cmd.op       = OP_WORD;
                    o_cmd.word_idx = r_widx[IDX_W-1:0];
                    n_widx         = r_widx + REM_W'(1);
                    if (n_widx == i_sts.word_cnt) begin
                        n_state = S_STAT;
                    end
                end
            end
            S_STAT: begin
                if (i_sts.out_free) begin
                    o_cmd.op         = OP_STATUS;
                    o_cmd.status     = r_st;
                    o_cmd.count_fail = r_cnt;
                    o_cmd.last       = 1'b1;
                    n_state          = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_sel  <= n_sel;
        r_end  <= n_end;
        r_widx <= n_widx;
        r_st   <= n_st;
        r_cnt  <= n_cnt;
    end
endmodule

[src/modbus_rtu_master_transaction.sv]
// Top level of the Modbus RTU master transaction engine.
// One request at a time: the input is ready only while the engine is idle, and each item is
// worked off before the next is taken. Each item is latched and then decoded; an ignored
// item or a tick that only counts down ends there. Each request byte that feeds the CRC is
// sent and then waits on the bitwise CRC-16 unit, which shifts eight times per byte; the CRC
// bytes themselves need no wait on it. A received byte before the CRC field also waits on
// the CRC unit; the last CRC byte brings out one word result per read register and then the
// status. A start with a bad count, a timeout or a line error gives a status only. Results
// leave through a one-entry output register, one per cycle while the sink is ready; a stalled
// sink holds the engine. There is no clearing pass after reset.
module modbus_rtu_master_transaction (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // function_kind, slave_address, start_register, register_count, word_value,
    // timeout_ticks, rx_byte, zero pad
    input  logic [87:0] s_axis_tdata,
    // action
    input  logic [2:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tx_byte, reg_index, reg_word, status, rx_error_count, zero pad
    output logic [63:0] m_axis_tdata,
    // kind
    output logic [1:0]  m_axis_tuser,
    output logic        m_axis_tlast,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data
);
    import mrtu_pkg::*;

    t_cmd cmd;
    t_sts sts;

    assign o_cfg_ready = 1'b1;

    mrtu_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    mrtu_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (s_axis_tdata),
        .i_in_user   (s_axis_tuser),
        .i_cfg_wr    (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_out_ready (m_axis_tready),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_valid (m_axis_tvalid),
        .o_out_user  (m_axis_tuser),
        .o_out_data  (m_axis_tdata),
        .o_out_last  (m_axis_tlast)
    );
endmodule

[sim/modbus_rtu_master_transaction_tb.sv]
// Self-checking testbench of the Modbus RTU master transaction engine.
`timescale 1ns / 100ps
module modbus_rtu_master_transaction_tb;
    import mrtu_pkg::*;

    typedef struct packed {
        logic [2:0]  action;
        logic [1:0]  fkind;
        logic [7:0]  slave;
        logic [15:0] first_reg;
        logic [15:0] reg_cnt;
        logic [15:0] word;
        logic [15:0] timeout;
        logic [7:0]  rx_byte;
    } t_request;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  tx_byte;
        logic [3:0]  reg_index;
        logic [15:0] reg_word;
        logic [2:0]  status;
        logic [31:0] err_count;
        logic        last;
    } t_result;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [87:0] s_axis_tdata;
    logic [2:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [63:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        m_axis_tlast;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [15:0] i_cfg_data;

    modbus_rtu_master_transaction u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    // engine shadow state
    logic [15:0] default_wait;
    logic [1:0]  phase;
    logic [1:0]  req_kind;
    logic [7:0]  tgt_slave;
    logic [15:0] echo_addr;
    logic [15:0] echo_word;
    logic [4:0]  words_left;
    logic [15:0] crc;
    logic [7:0]  rx_pos;
    logic [7:0]  held_byte;
    logic        hdr_bad;
    logic [15:0] wait_left;
    logic [15:0] read_words [MAX_REGS];
    logic [31:0] fail_count;

    t_request pending_q[$];
    t_result  expected_q[$];
    int       errors;
    int       results_seen;
    int       requests_sent;
    bit       hold_sender;
    bit       drive_done;
    bit       in_taken;

    function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] r;
        r = c ^ {8'h00, b};
        for (int k = 0; k < 8; k++)
            r = r[0] ? ((r >> 1) ^ 16'hA001) : (r >> 1);
        return r;
    endfunction

    function automatic logic [7:0] fcode(input logic [1:0] k);
        case (k)
            FK_READ:    return 8'h03;
            FK_WSINGLE: return 8'h06;
            FK_WMULTI:  return 8'h10;
            default:    return 8'h00;
        endcase
    endfunction

    task automatic push_result(input logic [1:0] kind, input logic [7:0] txb,
                               input logic [3:0] idx, input logic [15:0] w,
                               input logic [2:0] st, input logic [31:0] cnt);
        t_result r;
        r = '{kind, txb, idx, w, st, cnt, 1'b0};
        expected_q.push_back(r);
    endtask

    task automatic send_byte(input logic [7:0] b);
        crc = crc_byte(crc, b);
        push_result(KIND_TX, b, 4'd0, 16'd0, ST_OK, 32'd0);
    endtask

    task automatic close_frame(input logic [2:0] st, input bit counted);
        if (counted) fail_count = fail_count + 1;
        push_result(KIND_STATUS, 8'd0, 4'd0, 16'd0, st, fail_count);
        phase = PH_IDLE;
    endtask

    task automatic start_rx();
        phase = PH_RECV;
        rx_pos = 8'd0;
        crc = CRC_INIT;
        hdr_bad = 1'b0;
        held_byte = 8'd0;
    endtask

    task automatic send_crc();
        push_result(KIND_TX, crc[7:0], 4'd0, 16'd0, ST_OK, 32'd0);
        push_result(KIND_TX, crc[15:8], 4'd0, 16'd0, ST_OK, 32'd0);
        start_rx();
    endtask

    task automatic take_rx_byte(input logic [7:0] b);
        int          len;
        int          p;
        logic [7:0]  want;
        logic [15:0] got;
        p = rx_pos;
        len = (req_kind == FK_READ) ? 5 + 2 * echo_word : 8;
        if (p + 2 < len) begin
            crc = crc_byte(crc, b);
            if (p == 0) hdr_bad |= (b != tgt_slave);
            else if (p == 1) hdr_bad |= (b != fcode(req_kind));
            else if (req_kind == FK_READ) begin
                if (p == 2) hdr_bad |= (b != 8'((2 * echo_word) & 8'hFF));
                else if (((p - 3) & 1) == 0) held_byte = b;
                else if (((p - 3) >> 1) < MAX_REGS) read_words[(p - 3) >> 1] = {held_byte, b};
            end else begin
                case (p)
                    2: want = echo_addr[15:8];
                    3: want = echo_addr[7:0];
                    4: want = echo_word[15:8];
                    default: want = echo_word[7:0];
                endcase
                hdr_bad |= (b != want);
            end
        end else if (p + 2 == len) begin
            held_byte = b;
        end else begin
            got = {b, held_byte};
            if (hdr_bad) close_frame(ST_FRAME, 1);
            else if (got != crc) close_frame(ST_CRC, 1);
            else begin
                if (req_kind == FK_READ)
                    for (int i = 0; i < echo_word && i < MAX_REGS; i++)
                        push_result(KIND_WORD, 8'd0, 4'(i), read_words[i], ST_OK, 32'd0);
                close_frame(ST_OK, 0);
            end
        end
        rx_pos = 8'(p + 1);
    endtask

    task automatic predict(input t_request r);
        int before_n;
        before_n = expected_q.size();
        if (r.action == ACT_START && phase == PH_IDLE) begin
            if (r.fkind == 2'd3 || (r.fkind != FK_WSINGLE &&
                (r.reg_cnt == 0 || r.reg_cnt > MAX_REGS))) begin
                close_frame(ST_FRAME, 0);
            end else begin
                req_kind = r.fkind;
                tgt_slave = r.slave;
                echo_addr = r.first_reg;
                echo_word = (r.fkind == FK_WSINGLE) ? r.word : r.reg_cnt;
                wait_left = (r.timeout != 0) ? r.timeout : default_wait;
                crc = CRC_INIT;
                send_byte(tgt_slave);
                send_byte(fcode(r.fkind));
                send_byte(echo_addr[15:8]);
                send_byte(echo_addr[7:0]);
                send_byte(echo_word[15:8]);
                send_byte(echo_word[7:0]);
                if (r.fkind == FK_WMULTI) begin
                    send_byte(8'(2 * r.reg_cnt));
                    words_left = 5'(r.reg_cnt);
                    phase = PH_SEND;
                end else begin
                    send_crc();
                end
            end
        end else if (r.action == ACT_DATA && phase == PH_SEND) begin
            send_byte(r.word[15:8]);
            send_byte(r.word[7:0]);
            if (words_left > 0) words_left = words_left - 1;
            if (words_left == 0) send_crc();
        end else if (r.action == ACT_BYTE && phase == PH_RECV) begin
            take_rx_byte(r.rx_byte);
        end else if (r.action == ACT_TICK && phase == PH_RECV) begin
            if (wait_left <= 1) begin
                wait_left = 0;
                close_frame(ST_TIMEOUT, 1);
            end else begin
                wait_left = wait_left - 1;
            end
        end else if (r.action == ACT_LINE && phase == PH_RECV) begin
            close_frame(ST_LINE, 1);
        end
        if (expected_q.size() > before_n) expected_q[$].last = 1'b1;
    endtask

    function automatic int gap_len();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 55) return 0;
        if (sel < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // stimulus builders
    function automatic t_request noise();
        logic [95:0] bits;
        bits = {$urandom, $urandom, $urandom};
        return t_request'(bits[84:0]);
    endfunction

    function automatic t_request start_req(input logic [1:0] fk, input logic [7:0] sl,
                                           input logic [15:0] addr, input logic [15:0] cnt,
                                           input logic [15:0] w, input logic [15:0] to);
        t_request r;
        r = noise();
        r.action = ACT_START;
        r.fkind = fk;
        r.slave = sl;
        r.first_reg = addr;
        r.reg_cnt = cnt;
        r.word = w;
        r.timeout = to;
        return r;
    endfunction

    function automatic t_request act_req(input logic [2:0] act, input logic [15:0] w,
                                         input logic [7:0] b);
        t_request r;
        r = noise();
        r.action = act;
        r.word = w;
        r.rx_byte = b;
        return r;
    endfunction

    // queue a full transaction; mode 0 good, 1 bad crc, 2 one frame byte flipped, 3 short + line/tick
    task automatic queue_txn(input logic [1:0] fk, input int cnt, input int mode,
                             input logic [15:0] to);
        logic [7:0]  sl;
        logic [15:0] addr;
        logic [15:0] sw;
        logic [7:0]  frame [$];
        logic [15:0] c;
        int          n;
        sl = $urandom;
        addr = $urandom;
        sw = (fk == FK_WSINGLE) ? 16'($urandom) : 16'(cnt);
        pending_q.push_back(start_req(fk, sl, addr, 16'(cnt), sw, to));
        if (fk == FK_WMULTI)
            for (int i = 0; i < cnt; i++) pending_q.push_back(act_req(ACT_DATA, $urandom, 0));
        frame.push_back(sl);
        frame.push_back(fcode(fk));
        if (fk == FK_READ) begin
            frame.push_back(8'(2 * cnt));
            for (int i = 0; i < 2 * cnt; i++) frame.push_back($urandom);
        end else begin
            frame.push_back(addr[15:8]);
            frame.push_back(addr[7:0]);
            frame.push_back(sw[15:8]);
            frame.push_back(sw[7:0]);
        end
        if (mode == 2) frame[$urandom_range(0, frame.size() - 1)] ^= 8'(1 << $urandom_range(0, 7));
        c = CRC_INIT;
        foreach (frame[i]) c = crc_byte(c, frame[i]);
        if (mode == 1) c ^= 16'(1 << $urandom_range(0, 15));
        frame.push_back(c[7:0]);
        frame.push_back(c[15:8]);
        n = (mode == 3) ? $urandom_range(0, frame.size() - 1) : frame.size();
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 5) == 0) pending_q.push_back(act_req(ACT_TICK, 0, 0));
            pending_q.push_back(act_req(ACT_BYTE, 0, frame[i]));
        end
        if (mode == 3) begin
            if ($urandom_range(0, 1)) pending_q.push_back(act_req(ACT_LINE, 0, 0));
            else for (int i = 0; i < 20; i++) pending_q.push_back(act_req(ACT_TICK, 0, 0));
        end
    endtask

    task automatic wait_drained();
        while (pending_q.size() != 0 || expected_q.size() != 0 || s_axis_tvalid)
            @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    task automatic write_default(input logic [15:0] v);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        default_wait = v;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("FAIL modbus_rtu_master_transaction");
        $finish;
    end

    // request driver
    int src_gap;
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            src_gap = 0;
        end else if (s_axis_tvalid && !in_taken) begin
        end else if (src_gap > 0 || hold_sender || pending_q.size() == 0) begin
            if (src_gap > 0) src_gap--;
            s_axis_tvalid <= 1'b0;
        end else begin
            t_request r;
            r = pending_q.pop_front();
            s_axis_tvalid <= 1'b1;
            s_axis_tuser <= r.action;
            s_axis_tdata <= {6'd0, r.rx_byte, r.timeout, r.word, r.reg_cnt, r.first_reg,
                             r.slave, r.fkind};
            src_gap = gap_len();
        end
    end

    // prediction on acceptance, result sink and check
    int sink_gap;
    always @(posedge i_clk) begin
        in_taken = i_rst_n && s_axis_tvalid && s_axis_tready;
        if (in_taken) begin
            t_request r;
            r.action = s_axis_tuser;
            {r.rx_byte, r.timeout, r.word, r.reg_cnt, r.first_reg, r.slave, r.fkind}
                = s_axis_tdata[81:0];
            predict(r);
            requests_sent++;
        end
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            t_result e;
            results_seen++;
            if (expected_q.size() == 0) begin
                $error("unexpected result kind=%0d data=%h", m_axis_tuser, m_axis_tdata);
                errors++;
            end else begin
                e = expected_q.pop_front();
                if (m_axis_tuser !== e.kind) begin
                    $error("kind exp %0d got %0d", e.kind, m_axis_tuser); errors++; end
                if (m_axis_tdata[7:0] !== e.tx_byte) begin
                    $error("tx_byte exp %h got %h", e.tx_byte, m_axis_tdata[7:0]); errors++; end
                if (m_axis_tdata[11:8] !== e.reg_index) begin
                    $error("reg_index exp %0d got %0d", e.reg_index, m_axis_tdata[11:8]);
                    errors++; end
                if (m_axis_tdata[27:12] !== e.reg_word) begin
                    $error("reg_word exp %h got %h", e.reg_word, m_axis_tdata[27:12]);
                    errors++; end
                if (m_axis_tdata[30:28] !== e.status) begin
                    $error("status exp %0d got %0d", e.status, m_axis_tdata[30:28]); errors++; end
                if (m_axis_tdata[62:31] !== e.err_count) begin
                    $error("rx_error_count exp %0d got %0d", e.err_count, m_axis_tdata[62:31]);
                    errors++; end
                if (m_axis_tlast !== e.last) begin
                    $error("last exp %0d got %0d", e.last, m_axis_tlast); errors++; end
            end
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            sink_gap = 0;
        end else if (sink_gap > 0) begin
            sink_gap--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
            if (m_axis_tvalid && m_axis_tready) sink_gap = gap_len();
        end
    end

    initial begin
        int k;
        errors = 0; results_seen = 0; requests_sent = 0; hold_sender = 0;
        default_wait = DEF_TIMEOUT;
        phase = PH_IDLE; req_kind = 0; tgt_slave = 0; echo_addr = 0; echo_word = 0;
        words_left = 0; crc = CRC_INIT; rx_pos = 0; held_byte = 0; hdr_bad = 0;
        wait_left = 0; fail_count = 0;
        foreach (read_words[i]) read_words[i] = 16'd0;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0; s_axis_tdata = '0; s_axis_tuser = '0;
        m_axis_tready = 1'b0; i_cfg_valid = 1'b0; i_cfg_data = '0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: idle noise, bad counts, each function, extremes, timeouts
        pending_q.push_back(act_req(ACT_BYTE, 0, 8'hFF));
        pending_q.push_back(act_req(ACT_TICK, 0, 0));
        pending_q.push_back(act_req(ACT_DATA, 16'hFFFF, 0));
        pending_q.push_back(act_req(3'd7, 0, 0));
        pending_q.push_back(start_req(FK_READ, 8'hFF, 16'hFFFF, 16'd0, 0, 0));
        pending_q.push_back(start_req(FK_WMULTI, 8'h00, 16'h0000, 16'd17, 0, 0));
        pending_q.push_back(start_req(FK_READ, 8'h00, 16'h0000, 16'hFFFF, 0, 0));
        pending_q.push_back(start_req(2'd3, 8'h12, 16'h1234, 16'd1, 0, 0));
        queue_txn(FK_READ, 16, 0, 16'hFFFF);
        queue_txn(FK_WSINGLE, 1, 0, 0);
        queue_txn(FK_WMULTI, 1, 1, 0);
        queue_txn(FK_READ, 1, 2, 0);
        pending_q.push_back(start_req(FK_WSINGLE, 8'h01, 16'h0001, 16'd0, 16'hFFFF, 16'd1));
        pending_q.push_back(start_req(FK_READ, 8'h01, 16'h0001, 16'd1, 0, 0));
        pending_q.push_back(act_req(ACT_TICK, 0, 0));
        pending_q.push_back(act_req(ACT_LINE, 0, 0));
        wait_drained();

        // short default wait, then random traffic through several settings
        write_default(16'd1);
        queue_txn(FK_READ, 2, 3, 0);
        pending_q.push_back(start_req(FK_WSINGLE, 8'h55, 16'hAAAA, 0, 16'h5555, 0));
        pending_q.push_back(act_req(ACT_TICK, 0, 0));
        wait_drained();
        write_default(16'hFFFF);
        for (int ph = 0; ph < 3; ph++) begin
            if (ph == 1) write_default(16'd3);
            if (ph == 2) write_default(16'($urandom_range(2, 60000)));
            k = pending_q.size();
            while (pending_q.size() - k < 50) begin
                int sel;
                sel = $urandom_range(0, 99);
                if (sel < 80)
                    queue_txn(2'($urandom_range(0, 2)),
                              ($urandom_range(0, 9) == 0) ? 16 : $urandom_range(1, 4),
                              $urandom_range(0, 9) < 6 ? 0 : $urandom_range(1, 3),
                              16'($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8)));
                else if (sel < 88)
                    pending_q.push_back(start_req($urandom, $urandom, $urandom,
                        $urandom_range(0, 1) ? 16'($urandom) : 16'd0, $urandom, $urandom));
                else
                    pending_q.push_back(noise());
            end
            if (ph == 0) begin
                while (pending_q.size() > 25) @(posedge i_clk);
                hold_sender = 1;
                while (expected_q.size() != 0 || s_axis_tvalid) @(posedge i_clk);
                hold_sender = 0;
            end
            wait_drained();
        end

        $display("Covered %0d requests and %0d results over all functions,", requests_sent,
                 results_seen);
        $display("response errors, timeouts, line errors and four timeout defaults.");
        if (errors == 0 && expected_q.size() == 0) begin
            $display("PASS modbus_rtu_master_transaction");
        end else begin
            $display("FAIL modbus_rtu_master_transaction");
        end
        $finish;
    end
endmodule

[modbus_rtu_master_transaction.f]
+incdir+src
src/mrtu_pkg.sv
src/mrtu_dp.sv
src/mrtu_ctrl.sv
src/modbus_rtu_master_transaction.sv
sim/modbus_rtu_master_transaction_tb.sv
